@@ rtl/core/spa_pkg.sv @@
// Shared constants, codes and types of the slot pool allocator.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package spa_pkg;

  localparam int POOL_SLOTS = 1024;
  localparam int ID_BITS    = 48;

  localparam int SLOT_IDX_W = $clog2(POOL_SLOTS);
  localparam int CNT_W      = $clog2(POOL_SLOTS + 1);
  localparam int IDX_IN_W   = 16;
  localparam int STATUS_W   = 3;
  localparam int SLOT_W     = 10;
  localparam int UID_W      = 48;

  localparam logic OP_CREATE  = 1'b0;
  localparam logic OP_DESTROY = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FREE  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_IDS   = 3'd4;

  typedef enum logic [1:0] {
    K_CREATE,
    K_DESTROY,
    K_RANGE
  } kind_t;

  typedef struct packed {
    kind_t                 kind;
    logic [SLOT_IDX_W-1:0] index;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

endpackage

@@ rtl/core/spa_front.sv @@
// Front part of the slot pool allocator: accepts requests, classifies them
// and holds them in a two-entry queue for the back part. Uses spa_pkg.
`timescale 1ns / 1ps

module spa_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic                        opcode,
  input  logic [spa_pkg::IDX_IN_W-1:0] free_index,
  input  logic                        init_busy,
  input  logic                        take,
  output spa_pkg::q_head_t            head
);
  import spa_pkg::*;

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  cmd_t       in_cmd;
  logic       do_push;
  logic       do_take;

  assign full    = (cnt == 2'd2) || init_busy;
  assign do_push = push && !full;
  assign do_take = take && (cnt != 2'd0);

  always_comb begin
    in_cmd.index = SLOT_IDX_W'(free_index);
    if (opcode == OP_CREATE) begin
      in_cmd.kind = K_CREATE;
    end else if ({1'b0, free_index} >= (IDX_IN_W + 1)'(POOL_SLOTS)) begin
      in_cmd.kind = K_RANGE;
    end else begin
      in_cmd.kind = K_DESTROY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (do_push) begin
        entries[wr_ptr] <= in_cmd;
        wr_ptr          <= !wr_ptr;
      end
      if (do_take) begin
        rd_ptr <= !rd_ptr;
      end
      cnt <= cnt + 2'(do_push) - 2'(do_take);
    end
  end

  assign head.valid = (cnt != 2'd0);
  assign head.cmd   = entries[rd_ptr];

endmodule

@@ rtl/core/spa_back.sv @@
// Back part of the slot pool allocator: the free stack, the live marks, the
// id counter and the result register. Uses spa_pkg.
`timescale 1ns / 1ps

module spa_back (
  input  logic                         clk,
  input  logic                         rst,
  input  spa_pkg::q_head_t             head,
  output logic                         take,
  output logic                         init_busy,
  output logic                         empty,
  input  logic                         pop,
  output logic [spa_pkg::STATUS_W-1:0] status,
  output logic [spa_pkg::SLOT_W-1:0]   slot,
  output logic [spa_pkg::UID_W-1:0]    unique_id
);
  import spa_pkg::*;

  typedef enum logic [1:0] {
    S_INIT,
    S_READ,
    S_EXEC
  } state_t;

  state_t                state;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  logic [ID_BITS-1:0]    next_id;
  logic [ID_BITS-1:0]    next_id_next;
  logic [SLOT_IDX_W-1:0] clr;
  cmd_t                  cur;
  logic                  out_valid;

  logic [SLOT_IDX_W-1:0] stack_mem [POOL_SLOTS];
  logic                  live_mem  [POOL_SLOTS];
  logic [SLOT_IDX_W-1:0] stack_rd;
  logic                  live_rd;
  logic [SLOT_IDX_W-1:0] stack_ra;

  logic                  stk_we;
  logic [SLOT_IDX_W-1:0] stk_wa;
  logic [SLOT_IDX_W-1:0] stk_wd;
  logic                  live_we;
  logic [SLOT_IDX_W-1:0] live_wa;
  logic                  live_wd;

  logic [STATUS_W-1:0]   res_status;
  logic [SLOT_IDX_W-1:0] res_slot;
  logic [ID_BITS-1:0]    res_uid;
  logic [SLOT_IDX_W-1:0] pop_slot;

  assign init_busy = (state == S_INIT);
  assign take      = (state == S_READ) && head.valid && (!out_valid || pop);
  assign empty     = !out_valid;
  assign stack_ra  = (count == '0) ? '0 : SLOT_IDX_W'(count - CNT_W'(1));

  always_comb begin
    pop_slot = stack_rd;
    if ({1'b0, stack_rd} >= (SLOT_IDX_W + 1)'(POOL_SLOTS)) begin
      pop_slot = '0;
    end
  end

  always_comb begin
    res_status   = ST_OK;
    res_slot     = '0;
    res_uid      = '0;
    count_next   = count;
    next_id_next = next_id;
    stk_we       = 1'b0;
    stk_wa       = SLOT_IDX_W'(count);
    stk_wd       = cur.index;
    live_we      = 1'b0;
    live_wa      = cur.index;
    live_wd      = 1'b0;
    if (state == S_INIT) begin
      stk_we  = 1'b1;
      stk_wa  = clr;
      stk_wd  = clr;
      live_we = 1'b1;
      live_wa = clr;
    end else if (state == S_EXEC) begin
      case (cur.kind)
        K_CREATE: begin
          if (count == '0) begin
            res_status = ST_FULL;
          end else if (next_id == '1) begin
            res_status = ST_IDS;
          end else begin
            res_slot     = pop_slot;
            res_uid      = next_id;
            count_next   = count - CNT_W'(1);
            next_id_next = next_id + ID_BITS'(1);
            live_we      = 1'b1;
            live_wa      = pop_slot;
            live_wd      = 1'b1;
          end
        end
        K_DESTROY: begin
          if (!live_rd) begin
            res_status = ST_FREE;
          end else begin
            live_we = 1'b1;
            if (count < CNT_W'(POOL_SLOTS)) begin
              stk_we     = 1'b1;
              count_next = count + CNT_W'(1);
            end
          end
        end
        default: begin
          res_status = ST_RANGE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[stk_wa] <= stk_wd;
    end
    if (take) begin
      stack_rd <= stack_mem[stack_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (live_we) begin
      live_mem[live_wa] <= live_wd;
    end
    if (take) begin
      live_rd <= live_mem[head.cmd.index];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      count     <= CNT_W'(POOL_SLOTS);
      next_id   <= ID_BITS'(1);
      clr       <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_INIT: begin
          clr <= clr + SLOT_IDX_W'(1);
          if (clr == SLOT_IDX_W'(POOL_SLOTS - 1)) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          if (take) begin
            cur   <= head.cmd;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          count     <= count_next;
          next_id   <= next_id_next;
          status    <= res_status;
          slot      <= SLOT_W'(res_slot);
          unique_id <= UID_W'(res_uid);
          state     <= S_READ;
        end
        default: begin
          state <= S_READ;
        end
      endcase
      if (state == S_EXEC) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/core/slot_pool_allocator_with_ids.sv @@
// Top level of the slot pool allocator: joins the request front part and the
// execution back part. Depends on spa_pkg, spa_front and spa_back.
`timescale 1ns / 1ps

// Each request gives exactly one result. The back part reads the free stack
// and live marks in S_READ and writes them back in S_EXEC; both are
// synchronous memories with one read and one write port. A two-entry request
// queue lets new requests in while a result waits to be popped. After reset
// the block runs a pass over all 1024 entries that loads the free stack and
// clears the live marks; full stays high throughout it.
module slot_pool_allocator_with_ids (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic                         opcode,
  input  logic [spa_pkg::IDX_IN_W-1:0] free_index,
  output logic                         empty,
  input  logic                         pop,
  output logic [spa_pkg::STATUS_W-1:0] status,
  output logic [spa_pkg::SLOT_W-1:0]   slot,
  output logic [spa_pkg::UID_W-1:0]    unique_id
);
  import spa_pkg::*;

  q_head_t head;
  logic    take;
  logic    init_busy;

  spa_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .opcode     (opcode),
    .free_index (free_index),
    .init_busy  (init_busy),
    .take       (take),
    .head       (head)
  );

  spa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .take      (take),
    .init_busy (init_busy),
    .empty     (empty),
    .pop       (pop),
    .status    (status),
    .slot      (slot),
    .unique_id (unique_id)
  );

  a_init_no_result: assert property (@(posedge clk) disable iff (rst)
    init_busy |-> empty)
    else $error("A result appeared during the initialisation pass.");

  a_id_only_on_ok: assert property (@(posedge clk) disable iff (rst)
    (!empty && unique_id != '0) |-> status == ST_OK)
    else $error("An id was given with a failing status.");

  a_fail_zero_slot: assert property (@(posedge clk) disable iff (rst)
    (!empty && status != ST_OK) |-> (slot == '0 && unique_id == '0))
    else $error("A failed request returned a slot or an id.");

  a_take_needs_room: assert property (@(posedge clk) disable iff (rst)
    take |-> (head.valid && (empty || pop)))
    else $error("A request was taken with no room for its result.");

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for slot_pool_allocator_with_ids.
// Depends on spa_pkg and the RTL. Predicts each result and compares the
// status, slot and id with what the block returns.
`timescale 1ns / 1ps

module tb;
  import spa_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int SHOW_MAX   = 10;

  typedef struct {
    logic                op;
    logic [IDX_IN_W-1:0] idx;
  } request_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [UID_W-1:0]    uid;
  } outcome_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                push = 1'b0;
  logic                full;
  logic                opcode = OP_CREATE;
  logic [IDX_IN_W-1:0] free_index = '0;
  logic                empty;
  logic                pop = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;
  logic [UID_W-1:0]    unique_id;

  request_t pending[$];
  outcome_t results_due[$];

  logic [SLOT_IDX_W-1:0] free_stk[POOL_SLOTS];
  logic                  live[POOL_SLOTS];
  logic [CNT_W-1:0]      free_cnt;
  logic [ID_BITS-1:0]    next_uid;

  logic in_taken  = 1'b0;
  logic out_taken = 1'b0;
  logic calm      = 1'b0;
  int   send_wait = 0;
  int   pop_wait  = 0;
  int   n_queued  = 0;
  int   n_taken   = 0;
  int   idle_cycles = 0;
  int   errors    = 0;
  int   n_alloc = 0, n_full = 0, n_range = 0, n_dfree = 0, n_freed = 0;

  slot_pool_allocator_with_ids u_top (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .opcode     (opcode),
    .free_index (free_index),
    .empty      (empty),
    .pop        (pop),
    .status     (status),
    .slot       (slot),
    .unique_id  (unique_id)
  );

  always #5 clk = ~clk;

  function automatic void clear_pool();
    for (int i = 0; i < POOL_SLOTS; i++) begin
      free_stk[i] = SLOT_IDX_W'(i);
      live[i]     = 1'b0;
    end
    free_cnt = CNT_W'(POOL_SLOTS);
    next_uid = 1;
  endfunction

  function automatic outcome_t allocate_or_release(request_t rq);
    outcome_t              r;
    logic [SLOT_IDX_W-1:0] s;
    r = '{ST_OK, '0, '0};
    if (rq.op == OP_CREATE) begin
      if (free_cnt == 0) begin
        r.status = ST_FULL;
        n_full++;
      end else if (next_uid == {ID_BITS{1'b1}}) begin
        r.status = ST_IDS;
      end else begin
        free_cnt = free_cnt - 1'b1;
        s = free_stk[free_cnt];
        live[s] = 1'b1;
        r.slot = SLOT_W'(s);
        r.uid = UID_W'(next_uid);
        next_uid = next_uid + 1'b1;
        n_alloc++;
      end
    end else begin
      if (rq.idx >= POOL_SLOTS) begin
        r.status = ST_RANGE;
        n_range++;
      end else if (!live[rq.idx[SLOT_IDX_W-1:0]]) begin
        r.status = ST_FREE;
        n_dfree++;
      end else begin
        live[rq.idx[SLOT_IDX_W-1:0]] = 1'b0;
        free_stk[free_cnt] = rq.idx[SLOT_IDX_W-1:0];
        free_cnt = free_cnt + 1'b1;
        n_freed++;
      end
    end
    return r;
  endfunction

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [IDX_IN_W-1:0] pick_live();
    int start;
    int k;
    start = $urandom_range(0, POOL_SLOTS - 1);
    for (k = 0; k < POOL_SLOTS; k++) begin
      if (live[(start + k) % POOL_SLOTS]) return IDX_IN_W'((start + k) % POOL_SLOTS);
    end
    return IDX_IN_W'(start);
  endfunction

  // Request driver.
  always @(negedge clk) begin
    logic     go;
    request_t rq;
    go = push;
    if (rst) begin
      go = 1'b0;
    end else if (!push || in_taken) begin
      if (in_taken) send_wait = draw_gap();
      if (send_wait > 0) begin
        send_wait--;
        go = 1'b0;
      end else if (pending.size() > 0) begin
        rq = pending.pop_front();
        opcode <= rq.op;
        free_index <= rq.idx;
        go = 1'b1;
      end else begin
        go = 1'b0;
      end
    end
    push <= go;
  end

  // Result consumer.
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (out_taken) pop_wait = draw_gap();
      if (pop_wait > 0) begin
        pop_wait--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Monitor, checker and watchdog.
  always @(posedge clk) begin
    outcome_t want;
    logic     acc_in;
    logic     acc_out;
    acc_in  = !rst && push && !full;
    acc_out = !rst && pop && !empty;
    in_taken  <= acc_in;
    out_taken <= acc_out;
    if (acc_out) begin
      if (results_due.size() == 0) begin
        errors++;
        if (errors <= SHOW_MAX)
          $display("%0t: result with no request waiting: status %0d slot %0d id %h",
                   $realtime, status, slot, unique_id);
      end else begin
        want = results_due.pop_front();
        if (status !== want.status || slot !== want.slot || unique_id !== want.uid) begin
          errors++;
          if (errors <= SHOW_MAX)
            $display("%0t: mismatch: expected status %0d slot %0d id %h, got %0d %0d %h",
                     $realtime, want.status, want.slot, want.uid, status, slot, unique_id);
        end
      end
    end
    if (acc_in) begin
      results_due.push_back(allocate_or_release('{opcode, free_index}));
      n_taken++;
    end
    if (!rst) begin
      if (acc_in || acc_out) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("Simulation FAILED");
          $finish;
        end
      end
    end
  end

  task automatic send(logic op, logic [IDX_IN_W-1:0] idx);
    while (n_queued - n_taken >= 3) @(negedge clk);
    pending.push_back('{op, idx});
    n_queued++;
  endtask

  task automatic settle();
    while (n_taken != n_queued || results_due.size() != 0) @(negedge clk);
  endtask

  task automatic random_mix(int count, int create_pct);
    int r;
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < create_pct) begin
        send(OP_CREATE, IDX_IN_W'($urandom_range(0, 65535)));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 75) send(OP_DESTROY, pick_live());
        else if (r < 90) send(OP_DESTROY, IDX_IN_W'($urandom_range(0, POOL_SLOTS - 1)));
        else send(OP_DESTROY, IDX_IN_W'($urandom_range(POOL_SLOTS, 65535)));
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    int n_fill;
    clear_pool();
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    send(OP_CREATE, '0);
    send(OP_CREATE, '1);
    send(OP_CREATE, 16'h5A5A);
    send(OP_DESTROY, 16'd1022);
    send(OP_DESTROY, 16'd1022);
    send(OP_CREATE, 16'hA5A5);
    send(OP_DESTROY, 16'd1024);
    send(OP_DESTROY, 16'hFFFF);
    send(OP_DESTROY, 16'h8000);
    send(OP_DESTROY, 16'd0);
    send(OP_DESTROY, 16'd1023);
    send(OP_DESTROY, 16'd1021);
    send(OP_DESTROY, 16'd1022);
    send(OP_DESTROY, 16'd1023);
    send(OP_CREATE, 16'h0000);
    send(OP_DESTROY, 16'd1022);
    settle();

    random_mix(150, 85);
    settle();

    // Exhaust the pool so that further creates are refused.
    n_fill = int'(free_cnt) + 6;
    for (int i = 0; i < n_fill; i++) send(OP_CREATE, IDX_IN_W'($urandom_range(0, 65535)));
    random_mix(60, 25);
    settle();

    repeat (30) @(posedge clk);
    $display("Ran %0d requests: %0d slots handed out, %0d freed, %0d refused as pool full,",
             n_taken, n_alloc, n_freed, n_full);
    $display("%0d rejected as out of range and %0d as already free; %0d mismatches.",
             n_range, n_dfree, errors);
    if (errors == 0 && results_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
